// ----- rtl/ysc_pkg.sv -----
package ysc_pkg;

  // Output scale of the chromaticities and the fractional bits of all coefficients.
  localparam int Scale = 256;
  localparam int CoefFracBits = 12;
  localparam int ScaleLog2 = $clog2(Scale);

  // Channel, sum and chromaticity widths.
  localparam int ChanW = 8;
  localparam int SumW = 10;
  localparam int ChromW = 9;

  typedef logic signed [15:0] coef_t;
  typedef logic [2:0] locus_sel_t;

  // Color conversion coefficients in Q4.12.
  localparam coef_t CoefY = 16'sd4768;
  localparam coef_t CoefRv = 16'sd6541;
  localparam coef_t CoefGu = 16'sd1606;
  localparam coef_t CoefGv = 16'sd3342;
  localparam coef_t CoefBu = 16'sd8266;

  // Locus parabola rows in Q4.12: A_up, b_up, c_up, A_down, b_down, c_down.
  localparam int NumRows = 4;
  localparam coef_t LocusCoef [NumRows][6] = '{
    '{-16'sd16794, 16'sd13107, -16'sd1085, -16'sd2130, 16'sd1638, 16'sd819},
    '{-16'sd7546,  16'sd6264,  16'sd173,   -16'sd2981, 16'sd2485, 16'sd723},
    '{-16'sd20685, 16'sd15196, -16'sd1311, -16'sd2662, 16'sd205,  16'sd1475},
    '{-16'sd16794, 16'sd13967, -16'sd1393, -16'sd2540, 16'sd328,  16'sd1352}
  };

  // Configuration register indexes.
  localparam logic [1:0] RegExcludeWhite = 2'd0;
  localparam logic [1:0] RegLocusSelect = 2'd1;

  // Locus select codes.
  localparam locus_sel_t SelAll = 3'd0;
  localparam locus_sel_t SelLastRow = 3'd4;

  // White band bounds, compared as x*1000.
  localparam int WhiteLo = 327 * Scale;
  localparam int WhiteHi = 339 * Scale;

endpackage

// ----- rtl/ysc_csc.sv -----
module ysc_csc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [7:0]                 luma,
  input  logic [7:0]                 chroma_blue,
  input  logic [7:0]                 chroma_red,
  output logic                       out_valid,
  output logic [ysc_pkg::ChanW-1:0]  red,
  output logic [ysc_pkg::ChanW-1:0]  green,
  output logic [ysc_pkg::SumW-1:0]   sum
);

  localparam int ProdW = 24;
  localparam int AccW = 26;

  logic [2:0] valid_r;

  logic signed [ProdW-1:0] ly_r, rv_r, gu_r, gv_r, bu_r;
  logic signed [ProdW-1:0] ly_nxt, rv_nxt, gu_nxt, gv_nxt, bu_nxt;
  logic signed [9:0] yo, uo, vo;

  logic [ysc_pkg::ChanW-1:0] r_r, g_r, b_r, r_nxt, g_nxt, b_nxt;
  logic [ysc_pkg::ChanW-1:0] r2_r, g2_r;
  logic [ysc_pkg::SumW-1:0] sum_r;
  logic signed [AccW-1:0] acc_r, acc_g, acc_b;

  // Round-down to a channel, clamped to 0..255.
  function automatic logic [ysc_pkg::ChanW-1:0] to_chan(input logic signed [AccW-1:0] acc);
    logic [AccW-ysc_pkg::CoefFracBits-1:0] v;
    v = acc[AccW-1:ysc_pkg::CoefFracBits];
    if (acc[AccW-1]) begin
      return '0;
    end else if (v > (AccW - ysc_pkg::CoefFracBits)'(255)) begin
      return '1;
    end
    return v[ysc_pkg::ChanW-1:0];
  endfunction

  // Stage one: remove offsets and form the coefficient products.
  always_comb begin
    yo = $signed({2'b00, luma}) - 10'sd16;
    uo = $signed({2'b00, chroma_blue}) - 10'sd128;
    vo = $signed({2'b00, chroma_red}) - 10'sd128;
    ly_nxt = ProdW'(yo) * ProdW'(ysc_pkg::CoefY);
    rv_nxt = ProdW'(vo) * ProdW'(ysc_pkg::CoefRv);
    gu_nxt = ProdW'(uo) * ProdW'(ysc_pkg::CoefGu);
    gv_nxt = ProdW'(vo) * ProdW'(ysc_pkg::CoefGv);
    bu_nxt = ProdW'(uo) * ProdW'(ysc_pkg::CoefBu);
  end

  // Stage two: add, round and clamp.
  always_comb begin
    acc_r = AccW'(ly_r) + AccW'(rv_r) + AccW'(1 << (ysc_pkg::CoefFracBits - 1));
    acc_g = AccW'(ly_r) - AccW'(gu_r) - AccW'(gv_r)
            + AccW'(1 << (ysc_pkg::CoefFracBits - 1));
    acc_b = AccW'(ly_r) + AccW'(bu_r) + AccW'(1 << (ysc_pkg::CoefFracBits - 1));
    r_nxt = to_chan(acc_r);
    g_nxt = to_chan(acc_g);
    b_nxt = to_chan(acc_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  // Payload stages, including the channel sum in stage three.
  always_ff @(posedge clk) begin
    if (en) begin
      ly_r <= ly_nxt;
      rv_r <= rv_nxt;
      gu_r <= gu_nxt;
      gv_r <= gv_nxt;
      bu_r <= bu_nxt;
      r_r <= r_nxt;
      g_r <= g_nxt;
      b_r <= b_nxt;
      r2_r <= r_r;
      g2_r <= g_r;
      sum_r <= ysc_pkg::SumW'(r_r) + ysc_pkg::SumW'(g_r) + ysc_pkg::SumW'(b_r);
    end
  end

  assign out_valid = valid_r[2];
  assign red = r2_r;
  assign green = g2_r;
  assign sum = sum_r;

endmodule

// ----- rtl/ysc_div.sv -----
module ysc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ysc_pkg::ChanW-1:0]   red,
  input  logic [ysc_pkg::ChanW-1:0]   green,
  input  logic [ysc_pkg::SumW-1:0]    sum,
  output logic                        out_valid,
  output logic [ysc_pkg::ChromW-1:0]  red_q,
  output logic [ysc_pkg::ChromW-1:0]  green_q
);

  // Three quotient bits are resolved per stage, both channels side by side.
  localparam int NumStages = 3;
  localparam int StepsPerStage = 3;
  localparam int RemW = ysc_pkg::SumW;
  localparam int QW = ysc_pkg::ChromW;

  logic [NumStages-1:0] valid_r;
  logic [RemW-1:0] rem_r [NumStages][2];
  logic [RemW-1:0] rem_nxt [NumStages][2];
  logic [QW-1:0] q_r [NumStages][2];
  logic [QW-1:0] q_nxt [NumStages][2];
  logic [RemW-1:0] den_r [NumStages];
  logic [NumStages-1:0] zero_r;

  // One restoring step: shift in a zero, subtract when it fits.
  function automatic logic [RemW:0] div_step(input logic [RemW-1:0] rem,
                                             input logic [RemW-1:0] den);
    logic [RemW:0] t;
    t = {rem, 1'b0};
    if (t >= {1'b0, den}) begin
      return {1'b1, RemW'(t - {1'b0, den})};
    end
    return {1'b0, rem[RemW-2:0], 1'b0};
  endfunction

  always_comb begin
    logic [RemW:0] st;
    logic [RemW-1:0] rem;
    logic [QW-1:0] q;
    logic [RemW-1:0] den;
    for (int s = 0; s < NumStages; s++) begin
      for (int c = 0; c < 2; c++) begin
        if (s == 0) begin
          den = sum;
          rem = (c == 0) ? RemW'(red) : RemW'(green);
          // The top quotient bit needs no shift: the channel never exceeds the sum.
          if (rem >= den) begin
            q = QW'(1);
            rem = rem - den;
          end else begin
            q = '0;
          end
          for (int k = 1; k < StepsPerStage; k++) begin
            st = div_step(rem, den);
            q = {q[QW-2:0], st[RemW]};
            rem = st[RemW-1:0];
          end
        end else begin
          den = den_r[s-1];
          rem = rem_r[s-1][c];
          q = q_r[s-1][c];
          for (int k = 0; k < StepsPerStage; k++) begin
            st = div_step(rem, den);
            q = {q[QW-2:0], st[RemW]};
            rem = st[RemW-1:0];
          end
        end
        rem_nxt[s][c] = rem;
        q_nxt[s][c] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NumStages-2:0], in_valid};
    end
  end

  // A zero sum is carried along so that both quotients come out as zero.
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= sum;
      zero_r[0] <= (sum == '0);
      for (int s = 1; s < NumStages; s++) begin
        den_r[s] <= den_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
      for (int s = 0; s < NumStages; s++) begin
        for (int c = 0; c < 2; c++) begin
          rem_r[s][c] <= rem_nxt[s][c];
          q_r[s][c] <= q_nxt[s][c];
        end
      end
    end
  end

  assign out_valid = valid_r[NumStages-1];
  assign red_q = zero_r[NumStages-1] ? '0 : q_r[NumStages-1][0];
  assign green_q = zero_r[NumStages-1] ? '0 : q_r[NumStages-1][1];

endmodule

// ----- rtl/ysc_locus.sv -----
module ysc_locus (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        exclude_white,
  input  ysc_pkg::locus_sel_t         locus_select,
  input  logic                        in_valid,
  input  logic [ysc_pkg::ChromW-1:0]  rc,
  input  logic [ysc_pkg::ChromW-1:0]  gc,
  output logic                        out_valid,
  output logic [ysc_pkg::ChromW-1:0]  red_chromaticity,
  output logic [ysc_pkg::ChromW-1:0]  green_chromaticity,
  output logic                        in_locus,
  output logic                        is_white,
  output logic                        is_skin
);

  localparam int SqW = 2 * ysc_pkg::ChromW;
  localparam int PW = 40;

  logic [2:0] valid_r;
  logic [ysc_pkg::ChromW-1:0] rc1_r, gc1_r, rc2_r, gc2_r, rc3_r, gc3_r;
  logic [SqW-1:0] sq_r;
  logic signed [PW-1:0] pa_up_r, pb_up_r, pa_dn_r, pb_dn_r;
  logic signed [PW-1:0] c_up_r, c_dn_r;
  logic [1:0] row;
  logic row_ok;
  logic signed [PW-1:0] up, down, lhs;
  logic locus_nxt, white_nxt;
  logic locus_r, white_r;

  function automatic logic in_band(input logic [ysc_pkg::ChromW-1:0] x);
    logic [31:0] xs;
    xs = 32'(x) * 32'd1000;
    return (xs >= 32'(ysc_pkg::WhiteLo)) && (xs <= 32'(ysc_pkg::WhiteHi));
  endfunction

  // Row select; the user must keep the configuration steady while items flow; the block does not enforce it.
  always_comb begin
    row = 2'(locus_select - 3'd1);
    row_ok = (locus_select != ysc_pkg::SelAll) && (locus_select <= ysc_pkg::SelLastRow);
  end

  // Final stage: build both parabolas and compare.
  always_comb begin
    up = pa_up_r + (pb_up_r <<< ysc_pkg::ScaleLog2) + c_up_r;
    down = pa_dn_r + (pb_dn_r <<< ysc_pkg::ScaleLog2) + c_dn_r;
    lhs = PW'(gc2_r) <<< (ysc_pkg::ScaleLog2 + ysc_pkg::CoefFracBits);
    if (locus_select == ysc_pkg::SelAll) begin
      locus_nxt = 1'b1;
    end else if (row_ok) begin
      locus_nxt = (lhs > down) && (lhs < up);
    end else begin
      locus_nxt = 1'b0;
    end
    white_nxt = exclude_white && in_band(gc2_r) && in_band(rc2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one: square of red.
      rc1_r <= rc;
      gc1_r <= gc;
      sq_r <= SqW'(rc) * SqW'(rc);
      // Stage two: coefficient products.
      rc2_r <= rc1_r;
      gc2_r <= gc1_r;
      pa_up_r <= PW'(ysc_pkg::LocusCoef[row][0]) * PW'(signed'({1'b0, sq_r}));
      pb_up_r <= PW'(ysc_pkg::LocusCoef[row][1]) * PW'(signed'({1'b0, rc1_r}));
      c_up_r <= PW'(ysc_pkg::LocusCoef[row][2]) <<< (2 * ysc_pkg::ScaleLog2);
      pa_dn_r <= PW'(ysc_pkg::LocusCoef[row][3]) * PW'(signed'({1'b0, sq_r}));
      pb_dn_r <= PW'(ysc_pkg::LocusCoef[row][4]) * PW'(signed'({1'b0, rc1_r}));
      c_dn_r <= PW'(ysc_pkg::LocusCoef[row][5]) <<< (2 * ysc_pkg::ScaleLog2);
      // Stage three: result register.
      rc3_r <= rc2_r;
      gc3_r <= gc2_r;
      locus_r <= locus_nxt;
      white_r <= white_nxt;
    end
  end

  assign out_valid = valid_r[2];
  assign red_chromaticity = rc3_r;
  assign green_chromaticity = gc3_r;
  assign in_locus = locus_r;
  assign is_white = white_r;
  assign is_skin = locus_r && !white_r;

endmodule

// ----- rtl/yuv_skin_color_classifier.sv -----
// Throughput: one pixel per cycle; the whole pipeline holds while a valid result waits at a stalled output.
// Stages: 3 for color conversion and sum, 3 for the two dividers (3 quotient bits
// each), 3 for the locus products, compares and result register.
// Reset clears all valid bits; exclude_white resets to 1 and locus_select to 3.
module yuv_skin_color_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_luma,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_chroma_red,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_red_chromaticity,
  output logic [8:0] out_green_chromaticity,
  output logic       out_in_locus,
  output logic       out_is_white,
  output logic       out_is_skin,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  logic en;
  logic exclude_white_r;
  ysc_pkg::locus_sel_t locus_select_r;

  logic csc_valid;
  logic [ysc_pkg::ChanW-1:0] red, green;
  logic [ysc_pkg::SumW-1:0] sum;
  logic div_valid;
  logic [ysc_pkg::ChromW-1:0] rc, gc;

  // The pipeline advances unless a finished beat waits at the output.
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exclude_white_r <= 1'b1;
      locus_select_r <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ysc_pkg::RegExcludeWhite: exclude_white_r <= cfg_data[0];
        ysc_pkg::RegLocusSelect:  locus_select_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ysc_csc u_csc (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .luma        (in_luma),
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .out_valid   (csc_valid),
    .red         (red),
    .green       (green),
    .sum         (sum)
  );

  ysc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (csc_valid),
    .red       (red),
    .green     (green),
    .sum       (sum),
    .out_valid (div_valid),
    .red_q     (rc),
    .green_q   (gc)
  );

  ysc_locus u_locus (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .exclude_white      (exclude_white_r),
    .locus_select       (locus_select_r),
    .in_valid           (div_valid),
    .rc                 (rc),
    .gc                 (gc),
    .out_valid          (out_valid),
    .red_chromaticity   (out_red_chromaticity),
    .green_chromaticity (out_green_chromaticity),
    .in_locus           (out_in_locus),
    .is_white           (out_is_white),
    .is_skin            (out_is_skin)
  );

endmodule

// ----- bench/tb_yuv_skin_color_classifier.sv -----
`timescale 1ns / 100ps

module tb_yuv_skin_color_classifier;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } pixel_t;

  typedef struct packed {
    logic [8:0] rc;
    logic [8:0] gc;
    logic       locus;
    logic       white;
    logic       skin;
  } class_t;

  localparam int CycleLimit = 400000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_luma;
  logic [7:0] in_chroma_blue;
  logic [7:0] in_chroma_red;
  logic       out_valid;
  logic       out_stall;
  logic [8:0] out_red_chromaticity;
  logic [8:0] out_green_chromaticity;
  logic       out_in_locus;
  logic       out_is_white;
  logic       out_is_skin;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [2:0] cfg_data;

  yuv_skin_color_classifier uut (.*);

  // Shadow copy of the configuration registers.
  logic                excl_white_q;
  ysc_pkg::locus_sel_t locus_sel_q;

  pixel_t pixel_queue[$];
  class_t expected_classes[$];
  int     mismatch_count;
  int     cycle_count;
  int     drv_wait;
  int     mon_wait;
  int     hold_cycles;
  bit     hold_request;

  // Nearest Q(F) value of num/den, ties away from zero.
  function automatic longint to_fixed(longint num, longint den);
    longint one;
    one = longint'(1) << ysc_pkg::CoefFracBits;
    if (num < 0) return -((-num * one + den / 2) / den);
    return (num * one + den / 2) / den;
  endfunction

  function automatic longint clamp_channel(longint acc);
    longint v;
    if (acc < 0) return 0;
    v = acc >>> ysc_pkg::CoefFracBits;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic bit white_band(longint x);
    return x * 1000 >= longint'(ysc_pkg::WhiteLo) && x * 1000 <= longint'(ysc_pkg::WhiteHi);
  endfunction

  // Locus rows in units of 1/10000.
  function automatic longint locus_row(int row, int k);
    longint rows [4][6];
    rows = '{'{-41000, 32000, -2650, -5200, 4000, 2000},
             '{-18423, 15294, 422, -7279, 6066, 1766},
             '{-50500, 37100, -3200, -6500, 500, 3600},
             '{-41000, 34100, -3400, -6200, 800, 3300}};
    return to_fixed(rows[row][k], 10000);
  endfunction

  function automatic class_t classify_pixel(pixel_t p);
    longint yo, uo, vo, half, ly, r, g, b, sum, rc, gc, sc, lhs, up, down;
    class_t c;
    yo = longint'(p.luma) - 16;
    uo = longint'(p.cb) - 128;
    vo = longint'(p.cr) - 128;
    half = longint'(1) << (ysc_pkg::CoefFracBits - 1);
    ly = to_fixed(1164, 1000) * yo;
    r = clamp_channel(ly + to_fixed(1597, 1000) * vo + half);
    g = clamp_channel(ly - to_fixed(392, 1000) * uo - to_fixed(816, 1000) * vo + half);
    b = clamp_channel(ly + to_fixed(2018, 1000) * uo + half);
    sum = r + g + b;
    rc = 0;
    gc = 0;
    if (sum > 0) begin
      rc = r * ysc_pkg::Scale / sum;
      gc = g * ysc_pkg::Scale / sum;
    end
    sc = ysc_pkg::Scale;
    if (locus_sel_q == ysc_pkg::SelAll) begin
      c.locus = 1'b1;
    end else if (locus_sel_q <= ysc_pkg::SelLastRow) begin
      lhs = gc * sc * (longint'(1) << ysc_pkg::CoefFracBits);
      up = locus_row(locus_sel_q - 1, 0) * rc * rc + locus_row(locus_sel_q - 1, 1) * rc * sc
         + locus_row(locus_sel_q - 1, 2) * sc * sc;
      down = locus_row(locus_sel_q - 1, 3) * rc * rc + locus_row(locus_sel_q - 1, 4) * rc * sc
           + locus_row(locus_sel_q - 1, 5) * sc * sc;
      c.locus = (lhs > down) && (lhs < up);
    end else begin
      c.locus = 1'b0;
    end
    c.white = excl_white_q && white_band(gc) && white_band(rc);
    c.skin = c.locus && !c.white;
    c.rc = rc[8:0];
    c.gc = gc[8:0];
    return c;
  endfunction

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Input driver: a random gap before each beat, payload held while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_wait <= 0;
    end else if (in_valid && in_stall) begin
      // Hold the stalled beat.
    end else if (drv_wait > 0) begin
      in_valid <= 1'b0;
      drv_wait <= drv_wait - 1;
    end else if (pixel_queue.size() > 0) begin
      pixel_t p;
      p = pixel_queue.pop_front();
      expected_classes.push_back(classify_pixel(p));
      in_valid <= 1'b1;
      in_luma <= p.luma;
      in_chroma_blue <= p.cb;
      in_chroma_red <= p.cr;
      drv_wait <= ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall: random per beat, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mon_wait <= 0;
      hold_cycles <= 0;
    end else if (hold_request && hold_cycles == 0) begin
      hold_cycles <= 200;
      out_stall <= 1'b1;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_cycles == 1) begin
      hold_cycles <= 0;
      out_stall <= 1'b0;
    end else if (mon_wait > 0) begin
      mon_wait <= mon_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) mon_wait <= ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
    end
  end

  // Result monitor: compare each beat with the oldest expected class.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      class_t got, want;
      got = '{out_red_chromaticity, out_green_chromaticity, out_in_locus, out_is_white,
              out_is_skin};
      if (expected_classes.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_classes.pop_front();
        if (got !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ysc_pkg::RegExcludeWhite) excl_white_q = val[0];
    else if (idx == ysc_pkg::RegLocusSelect) locus_sel_q = val;
  endtask

  task automatic drain_results();
    while (pixel_queue.size() > 0 || expected_classes.size() > 0 || in_valid)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.luma = 8'($urandom_range(255));
    p.cb = 8'($urandom_range(255));
    p.cr = 8'($urandom_range(255));
    // Near-gray pixels land in the white band; skin tones sit at cr above cb.
    case ($urandom_range(3))
      0: begin
        p.cb = 8'(128 + $urandom_range(6) - 3);
        p.cr = 8'(128 + $urandom_range(6) - 3);
      end
      1: begin
        p.cb = 8'($urandom_range(90, 125));
        p.cr = 8'($urandom_range(135, 175));
      end
      default: ;
    endcase
    return p;
  endfunction

  // Stimulus.
  initial begin
    pixel_t p;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    excl_white_q = 1'b1;
    locus_sel_q = 3'd3;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels under reset settings: extremes, zero sum, gray, skin tones.
    for (int i = 0; i < 8; i++) begin
      p.luma = i[0] ? 8'hff : 8'h00;
      p.cb = i[1] ? 8'hff : 8'h00;
      p.cr = i[2] ? 8'hff : 8'h00;
      pixel_queue.push_back(p);
    end
    pixel_queue.push_back('{8'd16, 8'd128, 8'd128});
    pixel_queue.push_back('{8'd235, 8'd128, 8'd128});
    pixel_queue.push_back('{8'd128, 8'd128, 8'd128});
    pixel_queue.push_back('{8'd150, 8'd110, 8'd155});
    pixel_queue.push_back('{8'd100, 8'd115, 8'd150});
    pixel_queue.push_back('{8'd200, 8'd100, 8'd160});
    pixel_queue.push_back('{8'hAA, 8'h55, 8'hAA});
    pixel_queue.push_back('{8'h55, 8'hAA, 8'h55});
    drain_results();

    // Every locus row, the accept-all code and the unknown codes, white exclusion both ways.
    for (int phase = 0; phase < 16; phase++) begin
      write_reg(ysc_pkg::RegExcludeWhite, 3'($urandom_range(7)));
      write_reg(ysc_pkg::RegLocusSelect, 3'(phase % 8));
      if (phase == 3) write_reg(2'd3, 3'($urandom_range(7)));
      for (int i = 0; i < 50; i++) pixel_queue.push_back(random_pixel());
      if (phase == 5) begin
        hold_request = 1'b1;
        repeat (3) @(posedge clk);
        hold_request = 1'b0;
      end
      drain_results();
    end

    drain_results();
    if (mismatch_count == 0 && expected_classes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
